// ===== rtl/assert_macros.svh =====
// assertion macros for the frame decoder rtl
// expects clk and rst_n in the scope where a macro is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define IFCD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition must never be seen at a clock edge outside reset
`define IFCD_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== rtl/ifcd_pkg.sv =====
// shared types, frame layout constants and result codes of the ir climate frame decoder
// no dependencies
package ifcd_pkg;

    localparam int unsigned COPY_LEN = 18;
    localparam int unsigned COUNT_W  = 6;

    localparam logic [COUNT_W-1:0] SUM_END      = 6'd17;  // bytes 0..16 go into the sum
    localparam logic [COUNT_W-1:0] SECOND_START = 6'd18;
    localparam logic [COUNT_W-1:0] SECOND_END   = 6'd34;
    localparam logic [COUNT_W-1:0] PREFIX14_END = 6'd31;
    localparam logic [COUNT_W-1:0] MARK_POS     = 6'd32;
    localparam logic [COUNT_W-1:0] LAST_POS     = 6'd35;
    localparam logic [COUNT_W-1:0] COUNT_MAX    = 6'd63;

    localparam logic [7:0] HEADER_BYTE = 8'h23;
    localparam logic [7:0] MARKER_BYTE = 8'h24;

    // status codes
    localparam logic [1:0] STATUS_NONE    = 2'd0;
    localparam logic [1:0] STATUS_SUM_OK  = 2'd1;
    localparam logic [1:0] STATUS_SUM_BAD = 2'd2;

    // power codes
    localparam logic [1:0] POWER_OFF     = 2'd0;
    localparam logic [1:0] POWER_ON      = 2'd1;
    localparam logic [1:0] POWER_UNKNOWN = 2'd2;

    // mode codes
    localparam logic [2:0] MODE_FAN        = 3'd0;
    localparam logic [2:0] MODE_AUTO       = 3'd1;
    localparam logic [2:0] MODE_HEAT       = 3'd2;
    localparam logic [2:0] MODE_MAINT_HEAT = 3'd3;
    localparam logic [2:0] MODE_COOL       = 3'd4;
    localparam logic [2:0] MODE_DRY        = 3'd5;
    localparam logic [2:0] MODE_UNKNOWN    = 3'd6;

    localparam logic [2:0] FAN_MAX_SPEED = 3'd4;
    localparam logic [2:0] FAN_UNKNOWN   = 3'd5;

    // vane codes
    localparam logic [3:0] VANE_AUTO1   = 4'd0;
    localparam logic [3:0] VANE_UP      = 4'd1;
    localparam logic [3:0] VANE_UP1     = 4'd2;
    localparam logic [3:0] VANE_UP2     = 4'd3;
    localparam logic [3:0] VANE_UP3     = 4'd4;
    localparam logic [3:0] VANE_DOWN    = 4'd5;
    localparam logic [3:0] VANE_SWING   = 4'd6;
    localparam logic [3:0] VANE_AUTO2   = 4'd7;
    localparam logic [3:0] VANE_AUTO3   = 4'd8;
    localparam logic [3:0] VANE_UNKNOWN = 4'd9;

    localparam logic [3:0] WIDE_LAST_DIRECT = 4'd5;
    localparam logic [3:0] WIDE_SWING_RAW   = 4'hC;
    localparam logic [2:0] WIDE_SWING       = 3'd6;
    localparam logic [2:0] WIDE_UNKNOWN     = 3'd7;

    localparam logic [1:0] INSTALL_LEFT    = 2'd0;
    localparam logic [1:0] INSTALL_CENTER  = 2'd1;
    localparam logic [1:0] INSTALL_RIGHT   = 2'd2;
    localparam logic [1:0] INSTALL_UNKNOWN = 2'd3;

    localparam logic [8:0] TEMP_ZERO   = 9'd10;
    localparam logic [8:0] TEMP_OFFSET = 9'd16;

    // tap positions of the byte chain at the last byte of a 36-byte frame:
    // byte j (j <= 16) sits in cell 16 - j, byte 17 sits in cell 17
    localparam int unsigned TAP_B0  = 16;
    localparam int unsigned TAP_B5  = 11;
    localparam int unsigned TAP_B6  = 10;
    localparam int unsigned TAP_B7  = 9;
    localparam int unsigned TAP_B8  = 8;
    localparam int unsigned TAP_B9  = 7;
    localparam int unsigned TAP_B13 = 3;
    localparam int unsigned TAP_B14 = 2;
    localparam int unsigned TAP_B15 = 1;
    localparam int unsigned TAP_B17 = 17;
    localparam int unsigned TAP_HEAD = COPY_LEN - 1;

    typedef logic [COPY_LEN-1:0][7:0] copy_t;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       is_last;
    } byte_item_t;

    typedef struct packed {
        logic [1:0] status;
        logic [1:0] power;
        logic [2:0] mode;
        logic       isee_on;
        logic       clean_on;
        logic       plasma_on;
        logic [8:0] temperature;
        logic [2:0] fan_speed;
        logic [3:0] vane;
        logic [2:0] wide_vane;
        logic [1:0] area_mode;
        logic [1:0] install_position;
    } result_t;

    // frame checks gathered over the byte stream, handed to the decoder
    typedef struct packed {
        logic       length_ok;
        logic       repeat_ok;
        logic [7:0] sum;
    } frame_check_t;

endpackage

// ===== rtl/ifcd_cell.sv =====
// one byte cell of the frame copy chain
// no dependencies
module ifcd_cell (
    input  logic       clk,
    input  logic       shift_en,
    input  logic [7:0] din,
    output logic [7:0] dout
);

    logic [7:0] data_reg;
    logic [7:0] data_next;

    always_comb
    begin
        data_next = shift_en ? din : data_reg;
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign dout = data_reg;

endmodule

// ===== rtl/ifcd_chain.sv =====
// row of byte cells holding the first copy of the frame
// shifts in new bytes, then rotates so the head meets the repeated copy; uses ifcd_pkg, ifcd_cell
module ifcd_chain (
    input  logic           clk,
    input  logic           shift_en,
    input  logic           load_new,
    input  logic [7:0]     frame_byte,
    output ifcd_pkg::copy_t taps
);

    genvar i;
    generate
        for (i = 0; i < ifcd_pkg::COPY_LEN; i++)
        begin : g_cell
            logic [7:0] cell_din;
            if (i == 0)
            begin : g_first
                // new byte while filling, head wraps around afterwards
                assign cell_din = load_new ? frame_byte : taps[ifcd_pkg::TAP_HEAD];
            end
            else
            begin : g_rest
                assign cell_din = taps[i-1];
            end
            ifcd_cell u_cell (
                .clk      (clk),
                .shift_en (shift_en),
                .din      (cell_din),
                .dout     (taps[i])
            );
        end
    endgenerate

endmodule

// ===== rtl/ifcd_decode.sv =====
// field decoder: turns the stored frame bytes into the result codes
// uses ifcd_pkg
module ifcd_decode (
    input  ifcd_pkg::copy_t        taps,
    input  ifcd_pkg::frame_check_t check,
    output ifcd_pkg::result_t      result
);

    logic [7:0] b0, b5, b6, b7, b8, b9, b13, b14, b15, b17;
    logic       recog;
    ifcd_pkg::result_t fields;

    assign b0  = taps[ifcd_pkg::TAP_B0];
    assign b5  = taps[ifcd_pkg::TAP_B5];
    assign b6  = taps[ifcd_pkg::TAP_B6];
    assign b7  = taps[ifcd_pkg::TAP_B7];
    assign b8  = taps[ifcd_pkg::TAP_B8];
    assign b9  = taps[ifcd_pkg::TAP_B9];
    assign b13 = taps[ifcd_pkg::TAP_B13];
    assign b14 = taps[ifcd_pkg::TAP_B14];
    assign b15 = taps[ifcd_pkg::TAP_B15];
    assign b17 = taps[ifcd_pkg::TAP_B17];

    assign recog = check.length_ok && check.repeat_ok && (b0 == ifcd_pkg::HEADER_BYTE);

    always_comb
    begin
        fields = '0;

        fields.status = (check.sum == b17) ? ifcd_pkg::STATUS_SUM_OK
                                           : ifcd_pkg::STATUS_SUM_BAD;

        if (b5 == 8'h00)
            fields.power = ifcd_pkg::POWER_OFF;
        else if (b5 == 8'h20)
            fields.power = ifcd_pkg::POWER_ON;
        else
            fields.power = ifcd_pkg::POWER_UNKNOWN;

        unique case (b6 & 8'h38)
            8'h38:   fields.mode = ifcd_pkg::MODE_FAN;
            8'h20:   fields.mode = ifcd_pkg::MODE_AUTO;
            8'h08:   fields.mode = (b15 == 8'h20) ? ifcd_pkg::MODE_MAINT_HEAT
                                                  : ifcd_pkg::MODE_HEAT;
            8'h18:   fields.mode = ifcd_pkg::MODE_COOL;
            8'h10:   fields.mode = ifcd_pkg::MODE_DRY;
            default: fields.mode = ifcd_pkg::MODE_UNKNOWN;
        endcase

        fields.isee_on   = b6[6];
        fields.clean_on  = b14[2];
        fields.plasma_on = b15[6];

        fields.temperature = (b7 == 8'h00) ? ifcd_pkg::TEMP_ZERO
                                           : ({1'b0, b7} + ifcd_pkg::TEMP_OFFSET);

        fields.fan_speed = (b9[2:0] <= ifcd_pkg::FAN_MAX_SPEED) ? b9[2:0]
                                                                : ifcd_pkg::FAN_UNKNOWN;

        unique case (b9 & 8'hF8)
            8'h40:   fields.vane = ifcd_pkg::VANE_AUTO1;
            8'h48:   fields.vane = ifcd_pkg::VANE_UP;
            8'h50:   fields.vane = ifcd_pkg::VANE_UP1;
            8'h58:   fields.vane = ifcd_pkg::VANE_UP2;
            8'h60:   fields.vane = ifcd_pkg::VANE_UP3;
            8'h68:   fields.vane = ifcd_pkg::VANE_DOWN;
            8'h78:   fields.vane = ifcd_pkg::VANE_SWING;
            8'h80:   fields.vane = ifcd_pkg::VANE_AUTO2;
            8'hB8:   fields.vane = ifcd_pkg::VANE_AUTO3;
            default: fields.vane = ifcd_pkg::VANE_UNKNOWN;
        endcase

        if (b8[7:4] <= ifcd_pkg::WIDE_LAST_DIRECT)
            fields.wide_vane = b8[6:4];
        else if (b8[7:4] == ifcd_pkg::WIDE_SWING_RAW)
            fields.wide_vane = ifcd_pkg::WIDE_SWING;
        else
            fields.wide_vane = ifcd_pkg::WIDE_UNKNOWN;

        fields.area_mode = b13[7:6];

        unique case (b14 & 8'h18)
            8'h08:   fields.install_position = ifcd_pkg::INSTALL_LEFT;
            8'h10:   fields.install_position = ifcd_pkg::INSTALL_CENTER;
            8'h18:   fields.install_position = ifcd_pkg::INSTALL_RIGHT;
            default: fields.install_position = ifcd_pkg::INSTALL_UNKNOWN;
        endcase
    end

    // everything reads zero for a frame that is not recognized
    assign result = recog ? fields : '0;

endmodule

// ===== rtl/ir_climate_frame_decoder_core.sv =====
// ir climate frame decoder top: one byte transfer per cycle, one result per frame
// latency: the result is valid the cycle after the last byte's transfer
// throughput: one byte per cycle, held back only by a last byte while a result waits
// reset: rst_n async active low zeroes count, sum and marker, sets both match flags, drops
// the output valid; byte cells and the result payload keep no reset value
// uses ifcd_pkg, ifcd_chain, ifcd_decode and assert_macros.svh
`include "assert_macros.svh"

module ir_climate_frame_decoder_core (
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 byte_valid,
    output logic                 byte_ready,
    input  ifcd_pkg::byte_item_t byte_data,

    output logic                 result_valid,
    input  logic                 result_ready,
    output ifcd_pkg::result_t    result_data
);

    // frame tracking state
    logic [ifcd_pkg::COUNT_W-1:0] count_reg, count_next;
    logic [7:0]                   sum_reg, sum_next;
    logic                         match14_reg, match14_next;
    logic                         match17_reg, match17_next;
    logic                         marker_reg, marker_next;

    // output register
    logic                         result_valid_reg, result_valid_next;
    ifcd_pkg::result_t            result_data_reg, result_data_next;

    logic                         byte_xfer;
    logic                         last_xfer;
    logic                         filling;
    logic                         in_second;
    logic                         mismatch;

    ifcd_pkg::copy_t              taps;
    ifcd_pkg::frame_check_t       check;
    ifcd_pkg::result_t            decoded;

    // a byte that ends no frame never needs the output register,
    // so only a last byte waits for a pending result to drain
    assign byte_ready = !result_valid_reg || result_ready || !byte_data.is_last;
    assign byte_xfer  = byte_valid && byte_ready;
    assign last_xfer  = byte_xfer && byte_data.is_last;

    // first 18 bytes fill the chain, every later byte rotates it
    assign filling   = (count_reg < ifcd_pkg::SECOND_START);
    assign in_second = (count_reg >= ifcd_pkg::SECOND_START) &&
                       (count_reg <= ifcd_pkg::SECOND_END);
    // during the second copy the chain head holds the matching first-copy byte
    assign mismatch  = (taps[ifcd_pkg::TAP_HEAD] != byte_data.frame_byte);

    ifcd_chain u_chain (
        .clk        (clk),
        .shift_en   (byte_xfer),
        .load_new   (filling),
        .frame_byte (byte_data.frame_byte),
        .taps       (taps)
    );

    // checks for the frame as it stands before this byte; the last byte of a
    // 36-byte frame changes none of them
    always_comb
    begin
        check.length_ok = (count_reg == ifcd_pkg::LAST_POS);
        check.repeat_ok = match17_reg || (match14_reg && marker_reg);
        check.sum       = sum_reg;
    end

    ifcd_decode u_decode (
        .taps   (taps),
        .check  (check),
        .result (decoded)
    );

    // frame tracking next state
    always_comb
    begin
        count_next   = count_reg;
        sum_next     = sum_reg;
        match14_next = match14_reg;
        match17_next = match17_reg;
        marker_next  = marker_reg;

        if (byte_xfer)
        begin
            if (byte_data.is_last)
            begin
                // end of frame: back to the start-of-frame values
                count_next   = '0;
                sum_next     = '0;
                match14_next = 1'b1;
                match17_next = 1'b1;
                marker_next  = 1'b0;
            end
            else
            begin
                if (count_reg < ifcd_pkg::SUM_END)
                    sum_next = sum_reg + byte_data.frame_byte;
                if (in_second && mismatch)
                begin
                    match17_next = 1'b0;
                    if (count_reg <= ifcd_pkg::PREFIX14_END)
                        match14_next = 1'b0;
                end
                if (count_reg == ifcd_pkg::MARK_POS)
                    marker_next = (byte_data.frame_byte == ifcd_pkg::MARKER_BYTE);
                if (count_reg != ifcd_pkg::COUNT_MAX)
                    count_next = count_reg + 1'b1;
            end
        end
    end

    // output register next state
    always_comb
    begin
        result_valid_next = result_valid_reg;
        result_data_next  = result_data_reg;
        if (last_xfer)
        begin
            result_valid_next = 1'b1;
            result_data_next  = decoded;
        end
        else if (result_ready)
        begin
            result_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg        <= '0;
            sum_reg          <= '0;
            match14_reg      <= 1'b1;
            match17_reg      <= 1'b1;
            marker_reg       <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg        <= count_next;
            sum_reg          <= sum_next;
            match14_reg      <= match14_next;
            match17_reg      <= match17_next;
            marker_reg       <= marker_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // payload only, no reset
    always_ff @(posedge clk)
    begin
        result_data_reg <= result_data_next;
    end

    assign result_valid = result_valid_reg;
    assign result_data  = result_data_reg;

    // a pending result is never overwritten by a new frame end
    `IFCD_NEVER(a_no_result_overwrite,
        result_valid_reg && !result_ready && last_xfer,
        "result overwritten before transfer")
    // a byte inside a frame never produces a result
    `IFCD_ASSERT(a_no_result_mid_frame,
        (byte_xfer && !byte_data.is_last) |=> !$rose(result_valid_reg),
        "result raised without a last byte")
    // the frame count restarts after each frame end
    `IFCD_ASSERT(a_count_restart,
        last_xfer |=> (count_reg == '0) && match14_reg && match17_reg && !marker_reg,
        "frame state not restarted")
    // a full 14-byte repeat is implied by a full 17-byte repeat
    `IFCD_NEVER(a_match_order,
        match17_reg && !match14_reg,
        "match flags out of order")

endmodule
